@@ rtl/core/wsg_pkg.sv @@
// Package of the waveform sample generator: configuration and queue types,
// register indexes, wave mode codes, arithmetic constants and the sine table.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package wsg_pkg;

   // Phase accumulator and sine table geometry.
   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int FRAC_BITS        = 16;
   localparam int STEP_BITS        = 32;
   localparam int SUM_BITS         = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;

   // Sine addressing: index over the full turn, offset within a quadrant,
   // and the table address, which also reaches the entry at a quarter turn.
   localparam int SINE_SCALE     = 4 * SINE_TABLE_DEPTH;
   localparam int SINE_IDX_BITS  = $clog2(SINE_SCALE);
   localparam int SINE_PROD_BITS = FRAC_BITS + $clog2(SINE_SCALE + 1);
   localparam int SINE_OFS_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int TBL_ADDR_BITS  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_BITS      = 15;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVE_MODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_LEVEL   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DUTY_POINT  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SINE_AMPL   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SINE_OFFSET = 3'd6;

   localparam logic [1:0] MODE_SQUARE   = 2'd0;
   localparam logic [1:0] MODE_TRIANGLE = 2'd1;
   localparam logic [1:0] MODE_SINE     = 2'd2;

   // Output mapping: clamp to 0..5000 mV, 19 mV steps, 255 codes full scale.
   localparam int    LEVEL_MAX_MV    = 5000;
   localparam int    LEVEL_STEP_MV   = 19;
   localparam int    LEVEL_STEP_HALF = 9;
   localparam int    CODE_FULL_SCALE = 255;
   localparam int    Q19_SHIFT       = 18;
   localparam int    Q19_RECIP       = ((1 << Q19_SHIFT) + LEVEL_STEP_MV - 1) / LEVEL_STEP_MV;
   localparam int    CODE_SHIFT      = 32;
   localparam longint CODE_RECIP     = ((64'd1 << CODE_SHIFT) + LEVEL_MAX_MV - 1) / LEVEL_MAX_MV;
   localparam longint CODE_MULT      = CODE_RECIP * CODE_FULL_SCALE;

   localparam longint HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [1:0]                wave_mode;
      logic [STEP_BITS-1:0]      phase_step;
      logic signed [14:0]        high_level_mv;
      logic signed [14:0]        low_level_mv;
      logic [15:0]               duty_point;
      logic [13:0]               sine_amplitude_mv;
      logic signed [14:0]        sine_offset_mv;
   } cfg_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] frac;
      logic                 period_end;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LEVEL,
      ST_QUANT,
      ST_CODE
   } back_state_type;

   typedef logic [SINE_BITS-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave table, Q30 Taylor series of nine terms, scaled to 32767.
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    t;
      longint         sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         t = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (t > 64'd32767) begin
            t = 64'd32767;
         end
         tbl[k] = SINE_BITS'(t);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

@@ rtl/core/wsg_req_if.sv @@
// Request channel of the waveform sample generator: one sample tick per
// transaction, with the restart flag. No dependencies.
`default_nettype none

interface wsg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsg_rsp_if.sv @@
// Response channel of the waveform sample generator: one DAC code and the
// period end flag per transaction. No dependencies.
`default_nettype none

interface wsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_code;
   logic       period_end;

   modport source (output valid, output sample_code, output period_end, input ready);
   modport sink   (input valid, input sample_code, input period_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsg_csr.sv @@
// Configuration register bank of the waveform sample generator.
// Depends on wsg_pkg.
`default_nettype none

module wsg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wsg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output wsg_pkg::cfg_type                    cfg
);
   import wsg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_WAVE_MODE:   cfg_in.wave_mode         = csr_data[1:0];
            REG_PHASE_STEP:  cfg_in.phase_step        = csr_data[STEP_BITS-1:0];
            REG_HIGH_LEVEL:  cfg_in.high_level_mv     = csr_data[14:0];
            REG_LOW_LEVEL:   cfg_in.low_level_mv      = csr_data[14:0];
            REG_DUTY_POINT:  cfg_in.duty_point        = csr_data[15:0];
            REG_SINE_AMPL:   cfg_in.sine_amplitude_mv = csr_data[13:0];
            REG_SINE_OFFSET: cfg_in.sine_offset_mv    = csr_data[14:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mode         <= MODE_SQUARE;
         cfg_ff.phase_step        <= STEP_BITS'(4294967);
         cfg_ff.high_level_mv     <= 15'sd5000;
         cfg_ff.low_level_mv      <= 15'sd0;
         cfg_ff.duty_point        <= 16'd32768;
         cfg_ff.sine_amplitude_mv <= 14'd2500;
         cfg_ff.sine_offset_mv    <= 15'sd2500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/wsg_front.sv @@
// Front end: takes sample ticks, runs the phase accumulator and queues the
// phase fraction with its wrap flag. Depends on wsg_pkg and wsg_req_if.
`default_nettype none

module wsg_front (
   input  logic                        clock,
   input  logic                        reset,
   wsg_req_if.sink                     req_port,
   input  logic [wsg_pkg::STEP_BITS-1:0] phase_step,
   input  wsg_pkg::q_status_type       q_status,
   output logic                        q_push,
   output wsg_pkg::q_entry_type        q_push_data
);
   import wsg_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_cur;
   logic [SUM_BITS-1:0]   phase_sum;

   assign req_port.ready = !q_status.full;
   assign q_push         = req_port.valid && req_port.ready;

   always_comb begin
      // A restart clears the phase before this sample is produced.
      phase_cur = req_port.restart ? '0 : phase_ff;
      phase_sum = SUM_BITS'(phase_cur) + SUM_BITS'(phase_step);
      q_push_data.frac       = phase_cur[PHASE_BITS-1 -: FRAC_BITS];
      q_push_data.period_end = |phase_sum[SUM_BITS-1:PHASE_BITS];
      phase_in = q_push ? phase_sum[PHASE_BITS-1:0] : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/wsg_queue.sv @@
// Short queue between the front end and the back end.
// Depends on wsg_pkg.
`default_nettype none

module wsg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsg_pkg::q_entry_type   push_data,
   input  logic                   pop,
   output wsg_pkg::q_entry_type   head,
   output wsg_pkg::q_status_type  status
);
   import wsg_pkg::*;

   q_entry_type                 entry_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff;
   logic [QUEUE_COUNT_BITS-1:0] count_in;

   localparam logic [QUEUE_PTR_BITS-1:0]   LAST_PTR   = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_COUNT_BITS-1:0] FULL_COUNT = QUEUE_COUNT_BITS'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ rtl/core/wsg_back.sv @@
// Back end: turns a queued phase into a level, clamps and quantises it and
// holds the DAC code in the output register. Depends on wsg_pkg, wsg_rsp_if.
`default_nettype none

module wsg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wsg_pkg::cfg_type       cfg,
   input  wsg_pkg::q_entry_type   q_head,
   input  wsg_pkg::q_status_type  q_status,
   output logic                   q_pop,
   wsg_rsp_if.source              rsp_port
);
   import wsg_pkg::*;

   localparam logic [SINE_IDX_BITS-1:0] QUAD_1 = SINE_IDX_BITS'(SINE_TABLE_DEPTH);
   localparam logic [SINE_IDX_BITS-1:0] QUAD_2 = SINE_IDX_BITS'(2 * SINE_TABLE_DEPTH);
   localparam logic [SINE_IDX_BITS-1:0] QUAD_3 = SINE_IDX_BITS'(3 * SINE_TABLE_DEPTH);

   back_state_type state_ff;
   back_state_type state_in;

   logic signed [16:0] a_ff;
   logic signed [16:0] a_in;
   logic [14:0]        b_ff;
   logic [14:0]        b_in;
   logic signed [15:0] base_ff;
   logic signed [15:0] base_in;
   logic               sub_ff;
   logic               sub_in;
   logic               sine_ff;
   logic               sine_in;
   logic               end_ff;
   logic signed [32:0] prod_ff;
   logic signed [32:0] prod_in;
   logic signed [17:0] mv_ff;
   logic signed [17:0] mv_in;
   logic [12:0]        lvl_ff;
   logic [12:0]        lvl_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_code_ff;
   logic [7:0]         rsp_code_in;
   logic               rsp_end_ff;
   logic               out_write;

   // Operand fetch
   logic [FRAC_BITS-1:0]      frac;
   logic signed [15:0]        hi16;
   logic signed [15:0]        lo16;
   logic signed [15:0]        diff;
   logic [SINE_PROD_BITS-1:0] sine_prod;
   logic [SINE_IDX_BITS-1:0]  sine_idx;
   logic [1:0]                quad;
   logic [SINE_IDX_BITS-1:0]  quad_base;
   logic [SINE_IDX_BITS-1:0]  sine_ofs_wide;
   logic [SINE_OFS_BITS-1:0]  sine_ofs;
   logic [TBL_ADDR_BITS-1:0]  tbl_addr;
   logic [SINE_BITS-1:0]      sine_mag;

   // Level, quantise and code
   logic signed [32:0] rnd;
   logic signed [32:0] prod_rnd;
   logic signed [17:0] mag;
   logic signed [17:0] base18;
   logic [12:0]        q_num;
   logic [26:0]        q_prod;
   logic [8:0]         q_steps;
   logic [13:0]        lvl_wide;
   logic [40:0]        code_prod;

   always_comb begin
      frac = q_head.frac;
      hi16 = {cfg.high_level_mv[14], cfg.high_level_mv};
      lo16 = {cfg.low_level_mv[14], cfg.low_level_mv};
      diff = hi16 - lo16;

      sine_prod = SINE_PROD_BITS'(frac) * SINE_PROD_BITS'(SINE_SCALE);
      sine_idx  = sine_prod[FRAC_BITS +: SINE_IDX_BITS];
      if (sine_idx >= QUAD_3) begin
         quad      = 2'd3;
         quad_base = QUAD_3;
      end else if (sine_idx >= QUAD_2) begin
         quad      = 2'd2;
         quad_base = QUAD_2;
      end else if (sine_idx >= QUAD_1) begin
         quad      = 2'd1;
         quad_base = QUAD_1;
      end else begin
         quad      = 2'd0;
         quad_base = '0;
      end
      sine_ofs_wide = sine_idx - quad_base;
      sine_ofs      = sine_ofs_wide[SINE_OFS_BITS-1:0];
      // Odd quadrants run the table backwards from the quarter-turn entry.
      tbl_addr = quad[0] ? TBL_ADDR_BITS'(SINE_TABLE_DEPTH) - TBL_ADDR_BITS'(sine_ofs)
                         : TBL_ADDR_BITS'(sine_ofs);
      sine_mag = SINE_TABLE[tbl_addr];

      a_in    = '0;
      b_in    = '0;
      base_in = '0;
      sub_in  = 1'b0;
      sine_in = 1'b0;
      unique case (cfg.wave_mode)
         MODE_SQUARE: begin
            base_in = (frac < cfg.duty_point) ? hi16 : lo16;
         end
         MODE_TRIANGLE: begin
            a_in    = {diff[15], diff};
            b_in    = frac[14:0];
            base_in = frac[15] ? hi16 : lo16;
            sub_in  = frac[15];
         end
         MODE_SINE: begin
            a_in    = {3'b000, cfg.sine_amplitude_mv};
            b_in    = sine_mag;
            base_in = {cfg.sine_offset_mv[14], cfg.sine_offset_mv};
            sub_in  = quad[1];
            sine_in = 1'b1;
         end
         default: begin
            base_in = '0;
         end
      endcase
   end

   always_comb begin
      prod_in = a_ff * $signed({1'b0, b_ff});

      // The sine rounds to nearest; the triangle divides towards zero.
      if (sine_ff) begin
         rnd = 33'sd16384;
      end else if (prod_ff[32]) begin
         rnd = 33'sd32767;
      end else begin
         rnd = 33'sd0;
      end
      prod_rnd = prod_ff + rnd;
      mag      = prod_rnd[32:15];
      base18   = {{2{base_ff[15]}}, base_ff};
      mv_in    = sub_ff ? base18 - mag : base18 + mag;

      q_num    = mv_ff[12:0] + 13'(LEVEL_STEP_HALF);
      q_prod   = 27'(q_num) * 27'(Q19_RECIP);
      q_steps  = q_prod[Q19_SHIFT +: 9];
      lvl_wide = 14'(q_steps) * 14'(LEVEL_STEP_MV);
      if (mv_ff > 18'(LEVEL_MAX_MV)) begin
         lvl_in = 13'(LEVEL_MAX_MV);
      end else if (mv_ff[17]) begin
         lvl_in = '0;
      end else begin
         lvl_in = lvl_wide[12:0];
      end

      code_prod   = 41'(lvl_ff) * 41'(CODE_MULT);
      rsp_code_in = code_prod[CODE_SHIFT +: 8];
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      out_write    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_LEVEL;
         ST_LEVEL: state_in = ST_QUANT;
         ST_QUANT: state_in = ST_CODE;
         ST_CODE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               out_write    = 1'b1;
               rsp_valid_in = 1'b1;
               if (!q_status.empty) begin
                  q_pop    = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         base_ff <= base_in;
         sub_ff  <= sub_in;
         sine_ff <= sine_in;
         end_ff  <= q_head.period_end;
      end
      prod_ff <= prod_in;
      mv_ff   <= mv_in;
      if (state_ff == ST_QUANT) begin
         lvl_ff <= lvl_in;
      end
      if (out_write) begin
         rsp_code_ff <= rsp_code_in;
         rsp_end_ff  <= end_ff;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.sample_code = rsp_code_ff;
   assign rsp_port.period_end  = rsp_end_ff;

   a_mul_then_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_LEVEL))
      else $error("multiply stage not followed by level stage");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_valid_from_code: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CODE))
      else $error("response raised outside the code stage");

   a_level_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CODE) |-> (lvl_ff <= 13'(LEVEL_MAX_MV)))
      else $error("quantised level above full scale");

endmodule

`default_nettype wire

@@ rtl/core/waveform_sample_generator.sv @@
// Top level of the waveform sample generator: register bank, front end,
// queue and back end. Depends on wsg_pkg, wsg_req_if, wsg_rsp_if and all
// wsg_ modules.
`default_nettype none

// Each request transaction is one sample tick. The front end applies the
// restart flag, takes the top sixteen bits of the phase accumulator as the
// phase fraction, advances the phase by the configured step and flags a wrap
// as period_end; it then places the transaction in a two-entry queue. The
// back end turns the fraction into a level in millivolts (square, triangle,
// or sine from a quarter-wave table), clamps it to 0..5000 mV, rounds it to
// 19 mV steps and scales it to an 8-bit DAC code, 255 being 5 V. The back end
// is a four-step sequencer (operand fetch and table read together with the
// pop, multiply, level, quantise, then code into the output register); it
// works on one sample at a time, pops the next queued sample, if any, in the
// code step and holds in the code step while a finished result waits on the
// response channel. The multiply and the two reciprocal multiplications of
// the output mapping each have a step of their own. The front end keeps
// accepting requests while the queue has room, also while a finished result
// waits on the response channel. Configuration registers are written through
// the csr_ port in list order (0 wave mode, 1 phase step, 2 high level, 3 low
// level, 4 duty point, 5 sine amplitude, 6 sine offset); index 7 is ignored.
// They should be written only while no transaction is in flight.
// Reset is synchronous and active high; there is no start-up pass.

module waveform_sample_generator (
   input  logic                                clock,
   input  logic                                reset,
   wsg_req_if.sink                             req_port,
   wsg_rsp_if.source                           rsp_port,
   input  logic                                csr_write_enable,
   input  logic [wsg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import wsg_pkg::*;

   cfg_type      cfg;
   q_entry_type  q_push_data;
   q_entry_type  q_head;
   q_status_type q_status;
   logic         q_push;
   logic         q_pop;

   // Configuration registers, shared by both ends.
   wsg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   // The front end owns the phase accumulator and stalls only on a full queue.
   wsg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .phase_step  (cfg.phase_step),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // The queue decouples the two ends, so a stalled response channel does not
   // stop the request channel until the queue fills.
   wsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // The back end computes one sample at a time and drives the response.
   wsg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_head   (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire
